// ===== hdl/gated_window_statistics_macros.svh =====
// Assertion macros for the window statistics block.
// Define NO_ASSERTIONS to compile them out.
`ifndef GATED_WINDOW_STATISTICS_MACROS_SVH
`define GATED_WINDOW_STATISTICS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GWS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gws: same-cycle check failed");
`define GWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gws: next-cycle check failed");
`else
`define GWS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define GWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/gws_pkg.sv =====
package gws_pkg;

    localparam int WINDOW_DEF = 1000;

    // request codes
    localparam logic [1:0] REQ_ACCUM  = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;

    // configuration register indexes (byte address = 4 * index)
    localparam int         CFG_ADDR_W     = 5;
    localparam logic [2:0] REG_LIMIT_LOW  = 3'd0;
    localparam logic [2:0] REG_LIMIT_HIGH = 3'd1;
    localparam logic [2:0] REG_NOMINAL    = 3'd2;
    localparam logic [2:0] REG_LOW_EN     = 3'd3;
    localparam logic [2:0] REG_HIGH_EN    = 3'd4;
    localparam logic [2:0] REG_NOMINAL_EN = 3'd5;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               sample_valid;
        logic signed [31:0] sample_value;
    } t_in_req;

    typedef struct packed {
        logic               accepted;
        logic               stats_present;
        logic signed [31:0] window_average;
        logic signed [31:0] min_seen;
        logic signed [31:0] max_seen;
        logic [9:0]         window_count;
    } t_out_res;

endpackage

// ===== hdl/gated_window_statistics.sv =====
// Sequence: an accepted sample passes the band check (BAND0 to BAND2), SUB and ADD,
//   then the divider; a sample outside the band skips SUB and ADD; other requests go
//   straight to the divider, which is skipped while no sample is held.
// Throughput: o_in_stall holds new requests until the result leaves DONE; the bit-serial
//   average divider (one quotient bit per cycle over the SUM_W-bit sum) sets the pace.
// Reset: synchronous active low; the sample memory is not cleared, read only once written.
module gated_window_statistics #(
    parameter int WINDOW = gws_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gws_pkg::t_in_req              i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gws_pkg::t_out_res             o_out_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gws_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

`include "gated_window_statistics_macros.svh"

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = 32 + CNT_W;
    localparam int DIV_W  = $clog2(SUM_W);

    localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [DIV_W-1:0]  DIV_LAST  = DIV_W'(SUM_W - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BAND0   = 4'd1;
    localparam logic [3:0] S_BAND1   = 4'd2;
    localparam logic [3:0] S_BAND2   = 4'd3;
    localparam logic [3:0] S_SUB     = 4'd4;
    localparam logic [3:0] S_ADD     = 4'd5;
    localparam logic [3:0] S_DIVINIT = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_SIGN    = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    // configuration
    logic signed [31:0] r_lim_lo, r_lim_hi, r_nom;
    logic               r_lo_en, r_hi_en, r_nom_en;

    // control and statistics state
    logic [3:0]               r_state;
    logic [SLOT_W-1:0]        r_slot;
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [31:0]       r_min, r_max;
    logic                     r_seen;
    logic [DIV_W-1:0]         r_step;
    logic                     r_out_valid;

    // datapath
    gws_pkg::t_in_req         r_req;
    gws_pkg::t_out_res        r_out_res;
    logic                     r_acc;
    logic                     r_band_on;
    logic signed [37:0]       r_c2, r_a, r_b;
    logic [SUM_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_rem;
    logic                     r_neg;
    logic signed [31:0]       r_avg;
    logic signed [31:0]       r_rd_data;

    logic signed [31:0]       mem [0:WINDOW-1];

    logic                     cfg_wr;
    logic                     in_take;
    logic                     out_free;
    logic signed [37:0]       lo_x, hi_x, nom_x, v2_x, c2_w, a_w, b_w;
    logic                     outlier;
    logic signed [31:0]       v;
    logic [SUM_W-1:0]         sum_mag;
    logic [CNT_W:0]           div_trial, div_diff;
    logic                     div_ge;
    logic [CNT_W+9:0]         cnt_ext;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign in_take  = (r_state == S_IDLE) & i_in_valid;
    assign out_free = ~r_out_valid | ~i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    always_comb begin
        case (paddr[4:2])
            gws_pkg::REG_LIMIT_LOW:  prdata = r_lim_lo;
            gws_pkg::REG_LIMIT_HIGH: prdata = r_lim_hi;
            gws_pkg::REG_NOMINAL:    prdata = r_nom;
            gws_pkg::REG_LOW_EN:     prdata = {31'd0, r_lo_en};
            gws_pkg::REG_HIGH_EN:    prdata = {31'd0, r_hi_en};
            gws_pkg::REG_NOMINAL_EN: prdata = {31'd0, r_nom_en};
            default:                 prdata = 32'd0;
        endcase
    end

    // band terms at doubled scale: a = 2c + 6(lo - c) = 6lo - 2c2, likewise b
    assign v     = $signed(r_req.sample_value);
    assign lo_x  = 38'(r_lim_lo);
    assign hi_x  = 38'(r_lim_hi);
    assign nom_x = 38'(r_nom);
    assign v2_x  = 38'(v) <<< 1;
    assign c2_w  = r_nom_en ? (nom_x <<< 1) : (lo_x + hi_x);
    assign a_w   = (lo_x <<< 2) + (lo_x <<< 1) - (r_c2 <<< 1);
    assign b_w   = (hi_x <<< 2) + (hi_x <<< 1) - (r_c2 <<< 1);
    assign outlier = r_band_on &
                     (((v2_x < r_a) & (v2_x < r_b)) | ((v2_x > r_a) & (v2_x > r_b)));

    assign sum_mag   = r_sum[SUM_W-1] ? $unsigned(-r_sum) : $unsigned(r_sum);
    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_count});
    assign div_diff  = div_trial - {1'b0, r_count};
    assign cnt_ext   = {10'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_lo <= '0;
            r_lim_hi <= '0;
            r_nom    <= '0;
            r_lo_en  <= 1'b0;
            r_hi_en  <= 1'b0;
            r_nom_en <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                gws_pkg::REG_LIMIT_LOW:  r_lim_lo <= pwdata;
                gws_pkg::REG_LIMIT_HIGH: r_lim_hi <= pwdata;
                gws_pkg::REG_NOMINAL:    r_nom    <= pwdata;
                gws_pkg::REG_LOW_EN:     r_lo_en  <= pwdata[0];
                gws_pkg::REG_HIGH_EN:    r_hi_en  <= pwdata[0];
                gws_pkg::REG_NOMINAL_EN: r_nom_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    // sequencer and statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_seen      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == S_DONE && out_free) || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in_req.req_type)
                            gws_pkg::REQ_ACCUM: begin
                                r_state <= i_in_req.sample_valid ? S_BAND0 : S_DIVINIT;
                            end
                            gws_pkg::REQ_CLEAR: begin
                                r_slot  <= '0;
                                r_count <= '0;
                                r_sum   <= '0;
                                r_min   <= '0;
                                r_max   <= '0;
                                r_seen  <= 1'b0;
                                r_state <= S_DIVINIT;
                            end
                            gws_pkg::REQ_REPORT: r_state <= S_DIVINIT;
                            default:             r_state <= S_DIVINIT;
                        endcase
                    end
                end
                S_BAND0: r_state <= S_BAND1;
                S_BAND1: r_state <= S_BAND2;
                S_BAND2: r_state <= outlier ? S_DIVINIT : S_SUB;
                S_SUB: begin
                    // window full: retire the oldest sample at the write slot
                    if (r_count == WIN_CNT) begin
                        r_sum <= r_sum - SUM_W'(r_rd_data);
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum  <= r_sum + SUM_W'(v);
                    r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                    if (!r_seen || v < r_min) begin
                        r_min <= v;
                    end
                    if (!r_seen || v > r_max) begin
                        r_max <= v;
                    end
                    r_seen  <= 1'b1;
                    r_state <= S_DIVINIT;
                end
                S_DIVINIT: begin
                    r_step  <= DIV_LAST;
                    r_state <= r_seen ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_SIGN;
                    end
                    r_step <= r_step - 1'b1;
                end
                S_SIGN: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= i_in_req;
            r_acc <= 1'b0;
        end
        if (r_state == S_BAND0) begin
            r_c2      <= c2_w;
            r_band_on <= r_lo_en & r_hi_en & (r_lim_hi > r_lim_lo);
        end
        if (r_state == S_BAND1) begin
            r_a <= a_w;
            r_b <= b_w;
        end
        if (r_state == S_BAND2) begin
            r_acc <= ~outlier;
        end
        if (r_state == S_DIVINIT) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= sum_mag;
            r_rem <= '0;
            r_avg <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], div_ge};
        end
        if (r_state == S_SIGN) begin
            r_avg <= r_neg ? -$signed(r_quo[31:0]) : $signed(r_quo[31:0]);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_res.accepted       <= r_acc;
            r_out_res.stats_present  <= r_seen;
            r_out_res.window_average <= r_avg;
            r_out_res.min_seen       <= r_min;
            r_out_res.max_seen       <= r_max;
            r_out_res.window_count   <= cnt_ext[9:0];
        end
    end

    // sample memory, registered read at the write slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            mem[r_slot] <= v;
        end
        r_rd_data <= mem[r_slot];
    end

    `GWS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= WIN_CNT)
    `GWS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        in_take && i_in_req.req_type == gws_pkg::REQ_CLEAR, r_count == '0 && !r_seen)
    `GWS_ASSERT_SAME(a_count_seen, i_clk, i_rst_n,
        r_state == S_IDLE && r_count != '0, r_seen)
    `GWS_ASSERT_SAME(a_div_rem, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_count)
    `GWS_ASSERT_SAME(a_acc_seen, i_clk, i_rst_n, r_state == S_DONE && r_acc, r_seen)

endmodule
